### rtl/lkvc_pkg.sv
// Package for the LRU key-value cache: field widths, opcodes, constants and
// the command/status structs between the controller and the datapath.
// Depends on nothing.
`default_nettype none

package lkvc_pkg;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
    localparam logic [DATA_W-1:0] MISS_DATA = 32'hFFFF_FFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // input transfer: latch the item and the match vectors
        logic apply;     // update entries, access the value memory
        logic out_load;  // load the output register
    } lkvc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // output register is empty or is being taken
    } lkvc_stat_t;

endpackage

`default_nettype wire

### rtl/lkvc_ctrl.sv
// Controller state machine for the LRU key-value cache.
// Depends on lkvc_pkg for the command and status structs.
`default_nettype none

module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire lkvc_stat_t stat,
    output lkvc_cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_APPLY = 2'd1;
    localparam logic [1:0] ST_OUT   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.load     = 1'b0;
        cmd.apply    = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // Hold here while an earlier result still waits for its transfer.
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/lkvc_datapath.sv
// Datapath for the LRU key-value cache: per-entry key, age and valid cells,
// the value memory, the capacity register and the output register.
// Depends on lkvc_pkg for widths, opcodes and the command/status structs.
`default_nettype none

module lkvc_datapath
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire lkvc_cmd_t                cmd,
    output lkvc_stat_t                    stat,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CAP_W-1:0]         cfg_wr_data,
    input  wire logic                     opcode,
    input  wire logic signed [KEY_W-1:0]  key,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          found,
    output logic signed [DATA_W-1:0]      data
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AW = IW;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int XW = CW + CAP_W;

    logic [CAP_W-1:0]  capacity_reg;
    logic [KEY_W-1:0]  key_reg [ENTRIES];
    logic [AW-1:0]     age_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [CW-1:0]     occ_reg;

    logic              item_op_reg;
    logic [KEY_W-1:0]  item_key_reg;
    logic [DATA_W-1:0] item_value_reg;
    logic [ENTRIES-1:0] hit_vec_reg;
    logic [ENTRIES-1:0] victim_vec_reg;
    logic [ENTRIES-1:0] slot_vec_reg;
    logic              evict_reg;

    logic [DATA_W-1:0] mem [ENTRIES];
    logic [DATA_W-1:0] rdata_reg;

    logic              out_valid_reg;
    logic              found_reg;
    logic [DATA_W-1:0] data_reg;

    logic [ENTRIES-1:0] hit_cmb;
    logic [ENTRIES-1:0] victim_cmb;
    logic [ENTRIES-1:0] free_cmb;
    logic [ENTRIES-1:0] slot_cmb;
    logic [CW-1:0]     occ_m1;
    logic [XW-1:0]     cap_ext;
    logic [XW-1:0]     eff_cap;
    logic              evict_cmb;

    logic              item_hit;
    logic [AW-1:0]     hit_age;
    logic [IW-1:0]     hit_idx;
    logic [IW-1:0]     slot_idx;
    logic [IW-1:0]     mem_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
        end
    end

    // Match, victim and free-slot vectors, evaluated against the incoming item.
    always_comb
    begin
        occ_m1  = occ_reg - CW'(1);
        cap_ext = XW'(capacity_reg);
        if (cap_ext == XW'(0))
        begin
            eff_cap = XW'(1);
        end
        else if (cap_ext > XW'(ENTRIES))
        begin
            eff_cap = XW'(ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
        evict_cmb = (XW'(occ_reg) >= eff_cap);
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_cmb[i]    = valid_reg[i] && (key_reg[i] == KEY_W'(key));
            victim_cmb[i] = valid_reg[i] && (CW'(age_reg[i]) == occ_m1);
        end
        free_cmb = ~valid_reg | (evict_cmb ? victim_cmb : '0);
        // Isolate the lowest free slot.
        slot_cmb = free_cmb & (~free_cmb + ENTRIES'(1));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_op_reg    <= opcode;
            item_key_reg   <= KEY_W'(key);
            item_value_reg <= DATA_W'(value);
            hit_vec_reg    <= hit_cmb;
            victim_vec_reg <= victim_cmb;
            slot_vec_reg   <= slot_cmb;
            evict_reg      <= evict_cmb;
        end
    end

    // The match vector is one-hot or empty, so OR reductions give index and age.
    always_comb
    begin
        item_hit = |hit_vec_reg;
        hit_age  = '0;
        hit_idx  = '0;
        slot_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit_vec_reg[i])
            begin
                hit_age = hit_age | age_reg[i];
                hit_idx = hit_idx | IW'(i);
            end
            if (slot_vec_reg[i])
            begin
                slot_idx = slot_idx | IW'(i);
            end
        end
        mem_addr = item_hit ? hit_idx : slot_idx;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (cmd.apply && item_op_reg == OP_PUT && !item_hit && slot_vec_reg[i])
            begin
                key_reg[i] <= item_key_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else if (cmd.apply)
        begin
            if (item_hit)
            begin
                // Move the hit entry to the front; the ones ahead of it age by one.
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (hit_vec_reg[i])
                    begin
                        age_reg[i] <= '0;
                    end
                    else if (valid_reg[i] && age_reg[i] < hit_age)
                    begin
                        age_reg[i] <= age_reg[i] + AW'(1);
                    end
                end
            end
            else if (item_op_reg == OP_PUT)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot_vec_reg[i])
                    begin
                        valid_reg[i] <= 1'b1;
                        age_reg[i]   <= '0;
                    end
                    else if (evict_reg && victim_vec_reg[i])
                    begin
                        valid_reg[i] <= 1'b0;
                        age_reg[i]   <= '0;
                    end
                    else if (valid_reg[i])
                    begin
                        age_reg[i] <= age_reg[i] + AW'(1);
                    end
                end
                if (!evict_reg)
                begin
                    occ_reg <= occ_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            if (item_op_reg == OP_PUT)
            begin
                mem[mem_addr] <= item_value_reg;
            end
            else if (item_hit)
            begin
                rdata_reg <= mem[mem_addr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            found_reg <= item_hit;
            if (item_op_reg == OP_PUT)
            begin
                data_reg <= item_value_reg;
            end
            else if (item_hit)
            begin
                data_reg <= rdata_reg;
            end
            else
            begin
                data_reg <= MISS_DATA;
            end
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign data          = $signed(data_reg);

endmodule

`default_nettype wire

### rtl/lru_key_value_cache.sv
// Top level of the LRU key-value cache: controller plus datapath.
// Depends on lkvc_pkg, lkvc_ctrl and lkvc_datapath.
//
// Fully associative key-value cache with least-recently-used replacement,
// ENTRIES slots deep. Each item is a get (opcode 0) or a put (opcode 1); each
// gives one result with found set when the key was present and data holding
// the stored value (get hit), all ones (get miss) or the value written (put).
// For each item the key is compared against every entry in parallel in the
// cycle of its input transfer, the next cycle updates the ages and accesses
// the single-port value memory, and the output register is then loaded once
// it is free. The next item is taken in the cycle after that load, so a new
// item is accepted only after the previous one has loaded its result, also
// while that result still waits for its output transfer; the block stalls
// further only when a second result would have to enter a full output
// register. The capacity register (reset 16, zero acts as one, values above
// ENTRIES act as ENTRIES) is written through cfg_wr_en and cfg_wr_data; the
// user must do so only while the block is idle, which the block itself does
// not enforce. Valid marks and ages are cleared at reset.
`default_nettype none

module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CAP_W-1:0]         cfg_wr_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     opcode,
    input  wire logic signed [KEY_W-1:0]  key,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          found,
    output logic signed [DATA_W-1:0]      data
);

    lkvc_cmd_t  cmd;
    lkvc_stat_t stat;

    lkvc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lkvc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .opcode      (opcode),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .data        (data)
    );

endmodule

`default_nettype wire

### dv/tb_lru_key_value_cache.sv
// Self-checking testbench for lru_key_value_cache: directed cases and random
// get/put traffic over several capacity settings, checked against an LRU predictor.
// Depends on lkvc_pkg and the lru_key_value_cache RTL.
`default_nettype none

module tb_lru_key_value_cache;
    import lkvc_pkg::*;

    localparam int NUM_SLOTS = 16;

    typedef struct {
        logic              op;
        logic [KEY_W-1:0]  k;
        logic [DATA_W-1:0] v;
    } access_t;

    typedef struct {
        logic [KEY_W-1:0]  k;
        logic              hit;
        logic [DATA_W-1:0] payload;
    } answer_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CAP_W-1:0]         cfg_wr_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     opcode = OP_GET;
    logic signed [KEY_W-1:0]  key = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     found;
    logic signed [DATA_W-1:0] data;

    // Accesses waiting to be offered, and answers waiting to come out.
    access_t access_q[$];
    answer_t pending_answers[$];

    // Shadow copy of the cache contents.
    logic [KEY_W-1:0]  slot_key [NUM_SLOTS];
    logic [DATA_W-1:0] slot_val [NUM_SLOTS];
    logic              slot_used [NUM_SLOTS];
    int                slot_age [NUM_SLOTS];
    int                occupancy = 0;
    logic [CAP_W-1:0]  capacity_setting = CAP_RESET;

    bit quiet = 1'b0;
    int hold_left = 0;
    int mismatch_count = 0;
    int access_count = 0;
    int hit_count = 0;
    int evict_count = 0;
    int capacity_writes = 0;

    lru_key_value_cache #(.ENTRIES(NUM_SLOTS)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .key        (key),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .data       (data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int usable_capacity();
        int c;
        c = capacity_setting;
        if (c == 0) c = 1;
        if (c > NUM_SLOTS) c = NUM_SLOTS;
        return c;
    endfunction

    // Make slot s the most recent; everything more recent than it ages by one.
    function automatic void promote_slot(int s);
        for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_used[i] && i != s && slot_age[i] < slot_age[s])
                slot_age[i]++;
        slot_age[s] = 0;
    endfunction

    function automatic void predict_access(logic op, logic [KEY_W-1:0] k,
                                           logic [DATA_W-1:0] v);
        int      hit_slot;
        int      free_slot;
        int      victim;
        answer_t ans;
        hit_slot = -1;
        free_slot = -1;
        victim = -1;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
            if (slot_used[i] && slot_key[i] == k)
                hit_slot = i;
        ans.k = k;
        ans.hit = (hit_slot >= 0);
        if (hit_slot >= 0)
        begin
            hit_count++;
            if (op == OP_PUT)
                slot_val[hit_slot] = v;
            ans.payload = slot_val[hit_slot];
            promote_slot(hit_slot);
        end
        else if (op == OP_GET)
        begin
            ans.payload = MISS_DATA;
        end
        else
        begin
            ans.payload = v;
            if (occupancy >= usable_capacity())
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
                        victim = i;
                slot_used[victim] = 1'b0;
                slot_age[victim] = 0;
                occupancy--;
                evict_count++;
            end
            for (int i = NUM_SLOTS - 1; i >= 0; i--)
                if (!slot_used[i])
                    free_slot = i;
            for (int i = 0; i < NUM_SLOTS; i++)
                if (slot_used[i])
                    slot_age[i]++;
            slot_key[free_slot] = k;
            slot_val[free_slot] = v;
            slot_used[free_slot] = 1'b1;
            slot_age[free_slot] = 0;
            occupancy++;
        end
        access_count++;
        pending_answers.insert(pending_answers.size(), ans);
    endfunction

    // Request driver: the prediction is made at the transfer itself.
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        access_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode   <= OP_GET;
            key      <= '0;
            value    <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_access(opcode, key, value);
            if (!in_valid || in_ready)
            begin
                if (access_q.size() != 0 && (quiet || $urandom_range(99) >= 15))
                begin
                    nxt = access_q.pop_front();
                    in_valid <= 1'b1;
                    opcode   <= nxt.op;
                    key      <= nxt.k;
                    value    <= nxt.v;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor and output back-pressure.
    always @(posedge clk or negedge rst_n)
    begin : response_monitor
        answer_t exp_ans;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result with none expected: found %0b data %h",
                             $time, found, data);
                end
                else
                begin
                    exp_ans = pending_answers.pop_front();
                    if (found !== exp_ans.hit)
                    begin
                        mismatch_count++;
                        $display("%0t: key %h found: expected %0b, actual %0b",
                                 $time, exp_ans.k, exp_ans.hit, found);
                    end
                    if (data !== exp_ans.payload)
                    begin
                        mismatch_count++;
                        $display("%0t: key %h data: expected %h, actual %h",
                                 $time, exp_ans.k, exp_ans.payload, data);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= quiet || ($urandom_range(99) >= 15);
            end
        end
    end

    task automatic queue_access(input logic op, input logic [KEY_W-1:0] k,
                                input logic [DATA_W-1:0] v);
        access_t a;
        a.op = op;
        a.k = k;
        a.v = v;
        access_q.insert(access_q.size(), a);
    endtask

    task automatic wait_drained();
        while (access_q.size() != 0 || in_valid || pending_answers.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] c);
        wait_drained();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= c;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        capacity_setting = c;
        capacity_writes++;
        @(negedge clk);
    endtask

    // Keys come mostly from a pool a little larger than the capacity, so that
    // hits, updates and evictions all happen often.
    task automatic random_phase(input logic [CAP_W-1:0] c, input int n);
        logic [KEY_W-1:0] pool[$];
        logic [KEY_W-1:0] k;
        write_capacity(c);
        repeat (usable_capacity() + 4) pool.insert(pool.size(), $urandom);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                k = $urandom;
            else
                k = pool[$urandom_range(pool.size() - 1)];
            queue_access($urandom_range(1) ? OP_PUT : OP_GET, k, $urandom);
        end
    endtask

    initial
    begin : stimulus
        logic [CAP_W-1:0] phase_caps[10];
        phase_caps = '{5'd2, 5'd16, 5'd5, 5'd31, 5'd17, 5'd1, 5'd8, 5'd0, 5'd3, 5'd12};
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_used[i] = 1'b0;
            slot_age[i] = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Extreme keys and values, hits, a miss, an update in place.
        queue_access(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_access(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_access(OP_PUT, 32'h0000_0000, 32'h0000_0000);
        queue_access(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_access(OP_GET, 32'h7FFF_FFFF, 32'hA5A5_5A5A);
        queue_access(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_access(OP_GET, 32'd12345, 32'h0000_0000);
        queue_access(OP_PUT, 32'h0000_0000, 32'd55);
        queue_access(OP_GET, 32'h0000_0000, 32'h1234_5678);
        queue_access(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);

        // Capacity dropped below the occupancy: each new key evicts one entry.
        write_capacity(5'd1);
        queue_access(OP_PUT, 32'd7, 32'd70);
        queue_access(OP_PUT, 32'd8, 32'd80);
        queue_access(OP_GET, 32'd7, 32'hDEAD_BEEF);

        // A capacity of zero behaves as one.
        write_capacity(5'd0);
        queue_access(OP_PUT, 32'd9, 32'd90);
        queue_access(OP_GET, 32'd8, 32'd0);
        queue_access(OP_GET, 32'd9, 32'd0);

        for (int p = 0; p < 10; p++)
        begin
            random_phase(phase_caps[p], 153);
            // Stall the output long enough for the block to back up its input.
            if (p == 2)
                hold_left = 90;
            quiet = (p == 6);
        end
        wait_drained();
        quiet = 1'b0;
        repeat (10) @(negedge clk);

        $display("Ran %0d accesses: %0d hits, %0d misses, %0d evictions,",
                 access_count, hit_count, access_count - hit_count, evict_count);
        $display("over %0d capacity writes including zero and saturated values.",
                 capacity_writes);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : watchdog
        #(12 * 300000);
        $display("%0t: timeout with %0d results outstanding", $time, pending_answers.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
